// ----- hw/rtl/mke_pkg.sv -----
// shared types, constants and the letter-to-key table for the multitap keypad encoder
// no dependencies

package mke_pkg;

    localparam logic [3:0] NO_KEY       = 4'd15;
    localparam logic [3:0] PAUSE_SYMBOL = 4'd10;
    localparam logic [3:0] SPACE_KEY    = 4'd0;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_LOW_A   = 8'd97;
    localparam logic [7:0] CHAR_LOW_Z   = 8'd122;

    localparam int CMD_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_text;
    } char_item_t;

    typedef struct packed {
        logic [3:0] symbol;
        logic       bad_character;
        logic       last_of_run;
    } press_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [3:0] key;
        logic [2:0] presses;
        logic       pause;
        logic       bad;
    } press_cmd_t;

    typedef struct packed {
        logic [3:0] key;
        logic [2:0] presses;
    } letter_code_t;

    // letter index 0..25 to key digit and position on that key
    function automatic letter_code_t letter_code(input logic [4:0] idx);
        letter_code_t code;
        logic [4:0]   base;
        logic [4:0]   pos;
        code = '0;
        base = '0;
        case (idx) inside
            [5'd0:5'd2]:   begin code.key = 4'd2; base = 5'd0;  end
            [5'd3:5'd5]:   begin code.key = 4'd3; base = 5'd3;  end
            [5'd6:5'd8]:   begin code.key = 4'd4; base = 5'd6;  end
            [5'd9:5'd11]:  begin code.key = 4'd5; base = 5'd9;  end
            [5'd12:5'd14]: begin code.key = 4'd6; base = 5'd12; end
            [5'd15:5'd18]: begin code.key = 4'd7; base = 5'd15; end
            [5'd19:5'd21]: begin code.key = 4'd8; base = 5'd19; end
            default:       begin code.key = 4'd9; base = 5'd22; end
        endcase
        pos = idx - base + 5'd1;
        code.presses = pos[2:0];
        return code;
    endfunction

endpackage

// ----- hw/rtl/mke_front.sv -----
// front end: accepts characters, classifies them, tracks the previous key
// depends on mke_pkg

module mke_front
    import mke_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  char_item_t char_item,
    input  logic       q_full,
    output logic       cmd_push,
    output press_cmd_t cmd
);

    logic [3:0]   previous_key_reg;
    logic [3:0]   previous_key_next;
    logic [7:0]   letter_off;
    letter_code_t code;
    logic         is_space;
    logic         is_letter;

    assign cmd_push   = push && !q_full;
    assign letter_off = char_item.character - CHAR_LOW_A;
    assign code       = letter_code(letter_off[4:0]);
    assign is_space   = (char_item.character == CHAR_SPACE);
    assign is_letter  = (char_item.character >= CHAR_LOW_A) &&
                        (char_item.character <= CHAR_LOW_Z);

    always_comb
    begin
        cmd = '0;
        if (is_space)
        begin
            cmd.key     = SPACE_KEY;
            cmd.presses = 3'd1;
        end
        else if (is_letter)
        begin
            cmd.key     = code.key;
            cmd.presses = code.presses;
        end
        else
        begin
            cmd.bad     = 1'b1;
            cmd.presses = 3'd1;
        end
        cmd.pause = !cmd.bad && (previous_key_reg == cmd.key);
    end

    always_comb
    begin
        previous_key_next = previous_key_reg;
        if (cmd_push)
        begin
            if (char_item.end_of_text)
                previous_key_next = NO_KEY;
            else if (!cmd.bad)
                previous_key_next = cmd.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            previous_key_reg <= NO_KEY;
        else
            previous_key_reg <= previous_key_next;
    end

endmodule

// ----- hw/rtl/mke_queue.sv -----
// short command queue between front and back
// depends on mke_pkg

module mke_queue
    import mke_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  press_cmd_t din,
    output logic       full,
    input  logic       pop,
    output press_cmd_t dout,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    press_cmd_t       slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign dout    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/mke_back.sv -----
// back end: one command to pause and presses, a result per cycle unless stalled
// depends on mke_pkg; a bad character becomes one bad-character result

module mke_back
    import mke_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  press_cmd_t  cmd,
    input  logic        cmd_empty,
    output logic        cmd_pop,
    output press_item_t press_item,
    output logic        empty,
    input  logic        pop
);

    logic        valid_reg;
    logic        valid_next;
    press_item_t out_reg;
    press_item_t out_next;
    logic        pause_done_reg;
    logic        pause_done_next;
    logic [2:0]  press_cnt_reg;
    logic [2:0]  press_cnt_next;
    logic        advance;
    logic        produce;
    logic        cmd_done;

    assign empty      = !valid_reg;
    assign press_item = out_reg;
    assign advance    = !valid_reg || pop;
    assign produce    = advance && !cmd_empty;
    assign cmd_pop    = produce && cmd_done;

    // result for the current step of the head command
    always_comb
    begin
        out_next = '0;
        cmd_done = 1'b0;
        if (cmd.bad)
        begin
            out_next.bad_character = 1'b1;
            out_next.last_of_run   = 1'b1;
            cmd_done               = 1'b1;
        end
        else if (cmd.pause && !pause_done_reg)
        begin
            out_next.symbol = PAUSE_SYMBOL;
        end
        else
        begin
            out_next.symbol      = cmd.key;
            cmd_done             = (press_cnt_reg + 3'd1 == cmd.presses);
            out_next.last_of_run = cmd_done;
        end
    end

    always_comb
    begin
        valid_next      = valid_reg;
        pause_done_next = pause_done_reg;
        press_cnt_next  = press_cnt_reg;
        if (advance)
            valid_next = !cmd_empty;
        if (produce)
        begin
            if (cmd_done)
            begin
                pause_done_next = 1'b0;
                press_cnt_next  = '0;
            end
            else if (cmd.pause && !pause_done_reg)
                pause_done_next = 1'b1;
            else
                press_cnt_next = press_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            pause_done_reg <= 1'b0;
            press_cnt_reg  <= '0;
        end
        else
        begin
            valid_reg      <= valid_next;
            pause_done_reg <= pause_done_next;
            press_cnt_reg  <= press_cnt_next;
        end
    end

endmodule

// ----- hw/rtl/multitap_keypad_encoder.sv -----
// path: an accepted item goes through the command queue, then the back-end output register
// throughput: one result per cycle from the back-end sequencer while commands wait and
//   the output is not stalled; an item gives 1 to 5 results (pause plus up to four
//   presses); the front accepts every cycle while the command queue has room
// reset: asynchronous, active low; clears the previous key to none and empties the queue
//   and the output register

module multitap_keypad_encoder
    import mke_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // character items in
    input  logic        push,
    input  char_item_t  char_item,
    output logic        full,
    // press items out
    output logic        empty,
    input  logic        pop,
    output press_item_t press_item
);

    // classified commands between front and back
    logic       cmd_push;
    press_cmd_t cmd_in;
    press_cmd_t cmd_head;
    logic       q_full;
    logic       q_empty;
    logic       cmd_pop;

    assign full = q_full;

    // front: classify the character, decide pause, update the previous key
    mke_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .char_item (char_item),
        .q_full    (q_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    // short queue lets the front keep taking items while presses drain
    mke_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (q_full),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .empty (q_empty)
    );

    // back: one result per cycle, unless the output stalls, into the output register
    mke_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_head),
        .cmd_empty  (q_empty),
        .cmd_pop    (cmd_pop),
        .press_item (press_item),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
